// ----- hdl/frame_pacer_with_skip_macros.svh -----
// Assertion macros shared by the frame pacer RTL.
`ifndef FRAME_PACER_WITH_SKIP_MACROS_SVH
`define FRAME_PACER_WITH_SKIP_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define FPSK_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Consequence that must hold in the same cycle as its trigger.
`define FPSK_ASSERT_SAME(label, trig, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |-> (cond)) else $error(msg);

// Consequence that must hold in the cycle after its trigger.
`define FPSK_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cond)) else $error(msg);

`endif

// ----- hdl/fpsk_pkg.sv -----
// Types, constants and helpers for the frame pacer.
package fpsk_pkg;

    localparam int MS_PER_SEC = 1000;
    localparam int SPEED_IDLE = 100;
    localparam int FPS_W      = 10;
    localparam int SKIP_W     = 8;
    localparam int CNT32_W    = 32;
    localparam int LHS_W      = 42;
    localparam int DIV_W      = 42;
    localparam int MUL_W      = 52;
    localparam int MUL_STEPS  = 10;
    localparam int STEP_W     = 6;
    localparam int GAUGE_W    = 16;
    localparam int OUT_DATA_W = 104;
    localparam int OUT_USER_W = 2;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [FPS_W-1:0]  TARGET_FPS_RESET = 10'd25;
    localparam logic [SKIP_W-1:0] MAX_SKIP_RESET   = 8'd2;

    localparam logic REG_TARGET_FPS = 1'b0;
    localparam logic REG_MAX_SKIP   = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ELAPSED,
        ST_MUL,
        ST_CMP,
        ST_DIV_WAIT,
        ST_APPLY_WAIT,
        ST_WINDOW,
        ST_DIV_SPEED,
        ST_FINISH
    } state_t;

    function automatic logic [CNT32_W-1:0] sat_inc32(input logic [CNT32_W-1:0] v);
        return (&v) ? v : v + 32'd1;
    endfunction

endpackage

// ----- hdl/frame_pacer_with_skip.sv -----
// The first word after reset or a register write goes from the idle state straight to the
// finish state. Later words pass the elapsed, window and finish states and, as needed,
// a shift-add multiply over the ten target bits, a compare, an apply step and up to two
// passes of the shared restoring divider. One word is in flight at a time. The next word is
// accepted the cycle after the result register loads, which waits out an output stall.
// Reset is synchronous and active low; it loads the defaults and clears the control state.
`include "frame_pacer_with_skip_macros.svh"

module frame_pacer_with_skip #(
    parameter int TIME_BITS = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // now_ms[31:0]
    input  logic [31:0]                         s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // skip_frame[0], wait_ms[32:1], frame_time_ms[64:33], measured_fps[80:65],
    // speed_percent[96:81], zero padding[103:97]
    output logic [fpsk_pkg::OUT_DATA_W-1:0]     m_tdata,
    // first_frame[0], window_done[1]
    output logic [fpsk_pkg::OUT_USER_W-1:0]     m_tuser,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fpsk_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [fpsk_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [fpsk_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int CMP_W = (TIME_BITS > fpsk_pkg::LHS_W) ? TIME_BITS : fpsk_pkg::LHS_W;
    localparam int SUM_W = (TIME_BITS > 32) ? TIME_BITS : 32;

    fpsk_pkg::state_t state_reg, state_next;

    logic [fpsk_pkg::FPS_W-1:0]   tfps_reg, tfps_next;
    logic [fpsk_pkg::SKIP_W-1:0]  mskip_reg, mskip_next;
    logic                         started_reg, started_next;
    logic [TIME_BITS-1:0]         sync_start_reg, sync_start_next;
    logic [31:0]                  sync_frames_reg, sync_frames_next;
    logic [fpsk_pkg::SKIP_W-1:0]  skip_run_reg, skip_run_next;
    logic [TIME_BITS-1:0]         window_start_reg, window_start_next;
    logic [31:0]                  window_frames_reg, window_frames_next;
    logic [TIME_BITS-1:0]         last_start_reg, last_start_next;

    logic [TIME_BITS-1:0]         now_reg, now_next;
    logic [TIME_BITS-1:0]         e_reg, e_next;
    logic [TIME_BITS-1:0]         t_reg, t_next;
    logic [fpsk_pkg::LHS_W-1:0]   lhs_reg, lhs_next;
    logic [fpsk_pkg::MUL_W-1:0]   acc_reg, acc_next;
    logic [fpsk_pkg::MUL_W-1:0]   mcand_reg, mcand_next;
    logic [fpsk_pkg::FPS_W-1:0]   rem_reg, rem_next;
    logic [fpsk_pkg::STEP_W-1:0]  cnt_reg, cnt_next;
    logic [31:0]                  wait_reg, wait_next;
    logic [31:0]                  ftime_reg, ftime_next;
    logic                         first_reg, first_next;
    logic                         done_reg, done_next;
    logic [fpsk_pkg::GAUGE_W-1:0] mfps_reg, mfps_next;
    logic [fpsk_pkg::GAUGE_W-1:0] speed_reg, speed_next;

    logic                           m_valid_reg, m_valid_next;
    logic [fpsk_pkg::OUT_DATA_W-1:0] m_data_reg, m_data_next;
    logic [fpsk_pkg::OUT_USER_W-1:0] m_user_reg, m_user_next;

    logic                         cfg_wr;
    logic                         in_acc;
    logic [SUM_W-1:0]             now_ext;
    logic [TIME_BITS-1:0]         now_in;
    logic [SUM_W-1:0]             ftime_ext;
    logic [CMP_W-1:0]             e_cmp;
    logic [fpsk_pkg::LHS_W-1:0]   e_lo;
    logic [fpsk_pkg::LHS_W-1:0]   lhs_calc;
    logic [fpsk_pkg::DIV_W-1:0]   wf100;
    logic [11:0]                  div_part;
    logic [11:0]                  div_diff;
    logic                         div_ge;
    logic [fpsk_pkg::FPS_W-1:0]   div_rem;
    logic [fpsk_pkg::DIV_W-1:0]   div_quo;
    logic [fpsk_pkg::LHS_W-1:0]   wait_wide;
    logic [31:0]                  wait_sat;
    logic [SUM_W-1:0]             t_sum;
    logic [TIME_BITS-1:0]         wdiff;
    logic [fpsk_pkg::MUL_W-1:0]   lhs_mul;

    assign cfg_wr   = psel & penable & pwrite & pready;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == fpsk_pkg::REG_MAX_SKIP) ?
                      fpsk_pkg::APB_DATA_W'(mskip_reg) : fpsk_pkg::APB_DATA_W'(tfps_reg);
    assign s_tready = (state_reg == fpsk_pkg::ST_IDLE);
    assign in_acc   = s_tvalid & s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    assign now_ext   = SUM_W'(s_tdata);
    assign now_in    = now_ext[TIME_BITS-1:0];
    assign ftime_ext = SUM_W'(now_in - last_start_reg);
    assign e_cmp     = CMP_W'(e_reg);
    assign e_lo      = e_cmp[fpsk_pkg::LHS_W-1:0];
    assign lhs_calc  = fpsk_pkg::LHS_W'({sync_frames_reg, 10'b0})
                     - fpsk_pkg::LHS_W'({sync_frames_reg, 4'b0})
                     - fpsk_pkg::LHS_W'({sync_frames_reg, 3'b0});
    assign wf100     = fpsk_pkg::DIV_W'({window_frames_reg, 6'b0})
                     + fpsk_pkg::DIV_W'({window_frames_reg, 5'b0})
                     + fpsk_pkg::DIV_W'({window_frames_reg, 2'b0});
    assign lhs_mul   = fpsk_pkg::MUL_W'(lhs_reg);

    assign div_part = {1'b0, rem_reg, acc_reg[fpsk_pkg::DIV_W-1]};
    assign div_diff = div_part - {2'b0, tfps_reg};
    assign div_ge   = ~div_diff[11];
    assign div_rem  = div_ge ? div_diff[fpsk_pkg::FPS_W-1:0] : div_part[fpsk_pkg::FPS_W-1:0];
    assign div_quo  = {acc_reg[fpsk_pkg::DIV_W-2:0], div_ge};

    assign wait_wide = acc_reg[fpsk_pkg::DIV_W-1:0] - e_lo;
    assign wait_sat  = (|wait_wide[fpsk_pkg::LHS_W-1:32]) ? '1 : wait_wide[31:0];
    assign t_sum     = SUM_W'(now_reg) + SUM_W'(wait_sat);
    assign wdiff     = t_reg - window_start_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fpsk_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tfps_reg          <= fpsk_pkg::TARGET_FPS_RESET;
            mskip_reg         <= fpsk_pkg::MAX_SKIP_RESET;
            started_reg       <= 1'b0;
            sync_start_reg    <= '0;
            sync_frames_reg   <= '0;
            skip_run_reg      <= '0;
            window_start_reg  <= '0;
            window_frames_reg <= '0;
            last_start_reg    <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            tfps_reg          <= tfps_next;
            mskip_reg         <= mskip_next;
            started_reg       <= started_next;
            sync_start_reg    <= sync_start_next;
            sync_frames_reg   <= sync_frames_next;
            skip_run_reg      <= skip_run_next;
            window_start_reg  <= window_start_next;
            window_frames_reg <= window_frames_next;
            last_start_reg    <= last_start_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        now_reg    <= now_next;
        e_reg      <= e_next;
        t_reg      <= t_next;
        lhs_reg    <= lhs_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
        wait_reg   <= wait_next;
        ftime_reg  <= ftime_next;
        first_reg  <= first_next;
        done_reg   <= done_next;
        mfps_reg   <= mfps_next;
        speed_reg  <= speed_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    always_comb begin
        state_next         = state_reg;
        tfps_next          = tfps_reg;
        mskip_next         = mskip_reg;
        started_next       = started_reg;
        sync_start_next    = sync_start_reg;
        sync_frames_next   = sync_frames_reg;
        skip_run_next      = skip_run_reg;
        window_start_next  = window_start_reg;
        window_frames_next = window_frames_reg;
        last_start_next    = last_start_reg;
        now_next           = now_reg;
        e_next             = e_reg;
        t_next             = t_reg;
        lhs_next           = lhs_reg;
        acc_next           = acc_reg;
        mcand_next         = mcand_reg;
        rem_next           = rem_reg;
        cnt_next           = cnt_reg;
        wait_next          = wait_reg;
        ftime_next         = ftime_reg;
        first_next         = first_reg;
        done_next          = done_reg;
        mfps_next          = mfps_reg;
        speed_next         = speed_reg;
        m_valid_next       = m_valid_reg;
        m_data_next        = m_data_reg;
        m_user_next        = m_user_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            fpsk_pkg::ST_IDLE: begin
                if (in_acc) begin
                    now_next  = now_in;
                    t_next    = now_in;
                    wait_next = '0;
                    if (!started_reg) begin
                        started_next       = 1'b1;
                        sync_start_next    = now_in;
                        window_start_next  = now_in;
                        sync_frames_next   = '0;
                        window_frames_next = '0;
                        skip_run_next      = '0;
                        last_start_next    = now_in;
                        first_next         = 1'b1;
                        ftime_next         = '0;
                        done_next          = 1'b0;
                        mfps_next          = '0;
                        speed_next         = '0;
                        state_next         = fpsk_pkg::ST_FINISH;
                    end else begin
                        first_next         = 1'b0;
                        ftime_next         = ftime_ext[31:0];
                        window_frames_next = fpsk_pkg::sat_inc32(window_frames_reg);
                        if (tfps_reg != '0) begin
                            sync_frames_next = fpsk_pkg::sat_inc32(sync_frames_reg);
                        end
                        e_next     = now_in - sync_start_reg;
                        state_next = fpsk_pkg::ST_ELAPSED;
                    end
                end
            end
            fpsk_pkg::ST_ELAPSED: begin
                lhs_next = lhs_calc;
                if (tfps_reg == '0) begin
                    state_next = fpsk_pkg::ST_WINDOW;
                end else if (e_cmp > CMP_W'(lhs_calc)) begin
                    if (skip_run_reg < mskip_reg) begin
                        skip_run_next = skip_run_reg + 8'd1;
                    end else begin
                        sync_start_next  = now_reg;
                        sync_frames_next = '0;
                        skip_run_next    = '0;
                    end
                    state_next = fpsk_pkg::ST_WINDOW;
                end else begin
                    mcand_next = fpsk_pkg::MUL_W'(e_lo);
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = fpsk_pkg::ST_MUL;
                end
            end
            fpsk_pkg::ST_MUL: begin
                if (tfps_reg[cnt_reg[3:0]]) begin
                    acc_next = acc_reg + mcand_reg;
                end
                mcand_next = {mcand_reg[fpsk_pkg::MUL_W-2:0], 1'b0};
                cnt_next   = cnt_reg + 6'd1;
                if (cnt_reg == fpsk_pkg::STEP_W'(fpsk_pkg::MUL_STEPS - 1)) begin
                    state_next = fpsk_pkg::ST_CMP;
                end
            end
            fpsk_pkg::ST_CMP: begin
                if (lhs_mul == acc_reg) begin
                    sync_start_next  = now_reg;
                    sync_frames_next = '0;
                    skip_run_next    = '0;
                    state_next       = fpsk_pkg::ST_WINDOW;
                end else if (lhs_mul > acc_reg) begin
                    acc_next   = lhs_mul;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = fpsk_pkg::ST_DIV_WAIT;
                end else begin
                    if (skip_run_reg < mskip_reg) begin
                        skip_run_next = skip_run_reg + 8'd1;
                    end else begin
                        sync_start_next  = now_reg;
                        sync_frames_next = '0;
                        skip_run_next    = '0;
                    end
                    state_next = fpsk_pkg::ST_WINDOW;
                end
            end
            fpsk_pkg::ST_DIV_WAIT: begin
                acc_next = fpsk_pkg::MUL_W'(div_quo);
                rem_next = div_rem;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == fpsk_pkg::STEP_W'(fpsk_pkg::DIV_W - 1)) begin
                    state_next = fpsk_pkg::ST_APPLY_WAIT;
                end
            end
            fpsk_pkg::ST_APPLY_WAIT: begin
                wait_next     = wait_sat;
                t_next        = t_sum[TIME_BITS-1:0];
                skip_run_next = '0;
                state_next    = fpsk_pkg::ST_WINDOW;
            end
            fpsk_pkg::ST_WINDOW: begin
                last_start_next = t_reg;
                if (wdiff >= TIME_BITS'(fpsk_pkg::MS_PER_SEC)) begin
                    done_next          = 1'b1;
                    mfps_next          = (|window_frames_reg[31:16]) ? '1 :
                                         window_frames_reg[15:0];
                    window_start_next  = t_reg;
                    window_frames_next = '0;
                    if (tfps_reg != '0) begin
                        acc_next   = fpsk_pkg::MUL_W'(wf100);
                        rem_next   = '0;
                        cnt_next   = '0;
                        state_next = fpsk_pkg::ST_DIV_SPEED;
                    end else begin
                        speed_next = fpsk_pkg::GAUGE_W'(fpsk_pkg::SPEED_IDLE);
                        state_next = fpsk_pkg::ST_FINISH;
                    end
                end else begin
                    done_next  = 1'b0;
                    mfps_next  = '0;
                    speed_next = '0;
                    state_next = fpsk_pkg::ST_FINISH;
                end
            end
            fpsk_pkg::ST_DIV_SPEED: begin
                acc_next = fpsk_pkg::MUL_W'(div_quo);
                rem_next = div_rem;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == fpsk_pkg::STEP_W'(fpsk_pkg::DIV_W - 1)) begin
                    speed_next = (|div_quo[fpsk_pkg::DIV_W-1:16]) ? '1 : div_quo[15:0];
                    state_next = fpsk_pkg::ST_FINISH;
                end
            end
            fpsk_pkg::ST_FINISH: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = fpsk_pkg::OUT_DATA_W'({speed_reg, mfps_reg, ftime_reg,
                                                          wait_reg, (skip_run_reg != '0)});
                    m_user_next  = {done_reg, first_reg};
                    state_next   = fpsk_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = fpsk_pkg::ST_IDLE;
            end
        endcase

        if (cfg_wr) begin
            if (paddr[2] == fpsk_pkg::REG_TARGET_FPS) begin
                tfps_next = pwdata[fpsk_pkg::FPS_W-1:0];
            end else begin
                mskip_next = pwdata[fpsk_pkg::SKIP_W-1:0];
            end
            started_next       = 1'b0;
            sync_start_next    = '0;
            sync_frames_next   = '0;
            skip_run_next      = '0;
            window_start_next  = '0;
            window_frames_next = '0;
            last_start_next    = '0;
        end
    end

    `FPSK_ASSERT_SAME(a_first_clean, m_tvalid && m_tuser[0], m_tdata == '0, "First word carries data")
    `FPSK_ASSERT_SAME(a_gauges_idle, m_tvalid && !m_tuser[1], m_tdata[96:65] == '0, "Stale gauges")
    `FPSK_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "Second word taken too early")
    `FPSK_ASSERT_ALWAYS(a_skip_bound, skip_run_reg <= mskip_reg, "Skip run beyond limit")

endmodule

// ----- dv/tb_frame_pacer_with_skip.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the frame pacer: directed and random frame timestamps.
module tb_frame_pacer_with_skip;

    localparam int unsigned WINDOW_MS     = 1000;
    localparam int unsigned PERCENT       = 100;
    localparam int          SETTLE_CYCLES = 120;
    localparam int          CYCLE_LIMIT   = 1000000;
    localparam int          RANDOM_ITEMS  = 1850;

    localparam logic [fpsk_pkg::APB_ADDR_W-1:0] ADDR_TARGET_FPS =
        {fpsk_pkg::REG_TARGET_FPS, 2'b00};
    localparam logic [fpsk_pkg::APB_ADDR_W-1:0] ADDR_MAX_SKIP   =
        {fpsk_pkg::REG_MAX_SKIP, 2'b00};

    typedef struct packed {
        logic        first_frame;
        logic        skip_frame;
        logic [31:0] wait_ms;
        logic [31:0] frame_time_ms;
        logic        window_done;
        logic [15:0] measured_fps;
        logic [15:0] speed_percent;
    } pace_result_t;

    logic                            aclk     = 1'b0;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [31:0]                     s_tdata  = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [fpsk_pkg::OUT_DATA_W-1:0] m_tdata;
    logic [fpsk_pkg::OUT_USER_W-1:0] m_tuser;
    logic                            psel     = 1'b0;
    logic                            penable  = 1'b0;
    logic                            pwrite   = 1'b0;
    logic [fpsk_pkg::APB_ADDR_W-1:0] paddr    = '0;
    logic [fpsk_pkg::APB_DATA_W-1:0] pwdata   = '0;
    logic [fpsk_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    frame_pacer_with_skip DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    logic [31:0]  stamp_q[$];
    pace_result_t pace_exp_q[$];
    int           err_count    = 0;
    int           cycle_count  = 0;
    int           in_gap       = 0;
    int           out_gap      = 0;
    int           in_idle_max  = 3;
    int           out_idle_max = 3;

    // Pacer state and configuration as the block should hold them.
    logic                        started;
    logic [31:0]                 sync_start;
    logic [31:0]                 sync_frames;
    logic [7:0]                  skip_run;
    logic [31:0]                 window_start;
    logic [31:0]                 window_frames;
    logic [31:0]                 last_start;
    logic [fpsk_pkg::FPS_W-1:0]  cfg_fps;
    logic [fpsk_pkg::SKIP_W-1:0] cfg_max_skip;

    initial begin
        forever #5 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
        err_count++;
    endtask

    function automatic void clear_pacing();
        started       = 1'b0;
        sync_start    = '0;
        sync_frames   = '0;
        skip_run      = '0;
        window_start  = '0;
        window_frames = '0;
        last_start    = '0;
    endfunction

    function automatic pace_result_t pace_frame(input logic [31:0] now);
        pace_result_t r;
        logic [31:0]  t;
        logic [31:0]  elapsed;
        logic [63:0]  lhs;
        logic [63:0]  rhs;
        logic [63:0]  delay;
        logic [63:0]  speed;
        r = '0;
        if (!started) begin
            started       = 1'b1;
            sync_start    = now;
            window_start  = now;
            sync_frames   = '0;
            window_frames = '0;
            skip_run      = '0;
            last_start    = now;
            r.first_frame = 1'b1;
            return r;
        end
        t = now;
        r.frame_time_ms = now - last_start;
        if (~&window_frames)
            window_frames++;
        if (cfg_fps != 0) begin
            if (~&sync_frames)
                sync_frames++;
            elapsed = now - sync_start;
            lhs = 64'(sync_frames) * 64'(WINDOW_MS);
            rhs = 64'(cfg_fps) * 64'(elapsed);
            if (lhs > rhs) begin
                delay = lhs / 64'(cfg_fps) - 64'(elapsed);
                if (delay > 64'hFFFF_FFFF)
                    delay = 64'hFFFF_FFFF;
                r.wait_ms = delay[31:0];
                t = now + delay[31:0];
                skip_run = '0;
            end else if (lhs < rhs && skip_run < cfg_max_skip) begin
                skip_run++;
            end else begin
                sync_start  = now;
                sync_frames = '0;
                skip_run    = '0;
            end
        end
        if (t - window_start >= WINDOW_MS) begin
            r.window_done  = 1'b1;
            r.measured_fps = (window_frames > 32'hFFFF) ? 16'hFFFF : window_frames[15:0];
            if (cfg_fps != 0) begin
                speed = 64'(window_frames) * 64'(PERCENT) / 64'(cfg_fps);
                r.speed_percent = (speed > 64'hFFFF) ? 16'hFFFF : speed[15:0];
            end else begin
                r.speed_percent = 16'(PERCENT);
            end
            window_start  = t;
            window_frames = '0;
        end
        last_start   = t;
        r.skip_frame = (skip_run != 0);
        return r;
    endfunction

    // Frame timestamp driver.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            in_gap   <= 0;
        end else begin
            if (s_tvalid && s_tready)
                pace_exp_q.push_back(pace_frame(s_tdata));
            if (!s_tvalid || s_tready) begin
                if (in_gap != 0) begin
                    s_tvalid <= 1'b0;
                    in_gap   <= in_gap - 1;
                end else if (stamp_q.size() != 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= stamp_q.pop_front();
                    in_gap   <= $urandom_range(0, in_idle_max);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random back-pressure.
    always @(posedge aclk) begin : result_monitor
        pace_result_t got;
        pace_result_t want;
        int           next_gap;
        if (!aresetn) begin
            m_tready <= 1'b0;
            out_gap  <= 0;
        end else begin
            next_gap = out_gap;
            if (m_tvalid && m_tready) begin
                got.first_frame   = m_tuser[0];
                got.window_done   = m_tuser[1];
                got.skip_frame    = m_tdata[0];
                got.wait_ms       = m_tdata[32:1];
                got.frame_time_ms = m_tdata[64:33];
                got.measured_fps  = m_tdata[80:65];
                got.speed_percent = m_tdata[96:81];
                if (pace_exp_q.size() == 0) begin
                    report_mismatch("unexpected result word", m_tdata[63:0], 64'd0);
                end else begin
                    want = pace_exp_q.pop_front();
                    if (got.first_frame !== want.first_frame)
                        report_mismatch("first_frame", 64'(got.first_frame),
                                        64'(want.first_frame));
                    if (got.skip_frame !== want.skip_frame)
                        report_mismatch("skip_frame", 64'(got.skip_frame),
                                        64'(want.skip_frame));
                    if (got.wait_ms !== want.wait_ms)
                        report_mismatch("wait_ms", 64'(got.wait_ms), 64'(want.wait_ms));
                    if (got.frame_time_ms !== want.frame_time_ms)
                        report_mismatch("frame_time_ms", 64'(got.frame_time_ms),
                                        64'(want.frame_time_ms));
                    if (got.window_done !== want.window_done)
                        report_mismatch("window_done", 64'(got.window_done),
                                        64'(want.window_done));
                    if (got.measured_fps !== want.measured_fps)
                        report_mismatch("measured_fps", 64'(got.measured_fps),
                                        64'(want.measured_fps));
                    if (got.speed_percent !== want.speed_percent)
                        report_mismatch("speed_percent", 64'(got.speed_percent),
                                        64'(want.speed_percent));
                end
                next_gap = $urandom_range(0, out_idle_max);
            end
            if (next_gap != 0) begin
                m_tready <= 1'b0;
                out_gap  <= next_gap - 1;
            end else begin
                m_tready <= 1'b1;
                out_gap  <= 0;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // One register access; a read is checked against the given value.
    task automatic apb_access(input logic is_write,
                              input logic [fpsk_pkg::APB_ADDR_W-1:0] addr,
                              input logic [fpsk_pkg::APB_DATA_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (!is_write && prdata !== value)
            report_mismatch("register readback", 64'(prdata), 64'(value));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_pacing(input logic [fpsk_pkg::FPS_W-1:0] fps,
                              input logic [fpsk_pkg::SKIP_W-1:0] skip);
        apb_access(1'b1, ADDR_TARGET_FPS, fpsk_pkg::APB_DATA_W'(fps));
        cfg_fps = fps;
        clear_pacing();
        apb_access(1'b1, ADDR_MAX_SKIP, fpsk_pkg::APB_DATA_W'(skip));
        cfg_max_skip = skip;
        clear_pacing();
        apb_access(1'b0, ADDR_TARGET_FPS, fpsk_pkg::APB_DATA_W'(fps));
        apb_access(1'b0, ADDR_MAX_SKIP, fpsk_pkg::APB_DATA_W'(skip));
    endtask

    task automatic drain();
        do @(posedge aclk);
        while (stamp_q.size() != 0 || s_tvalid || pace_exp_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [fpsk_pkg::FPS_W-1:0] pick_fps();
        logic [fpsk_pkg::FPS_W-1:0] divisors[11] = '{10'd1, 10'd8, 10'd25, 10'd40, 10'd50,
                                                     10'd100, 10'd125, 10'd200, 10'd250,
                                                     10'd500, 10'd1000};
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 10'd1;
            2:       return 10'd1000;
            3:       return divisors[$urandom_range(0, 10)];
            default: return 10'($urandom_range(1, 1000));
        endcase
    endfunction

    function automatic logic [fpsk_pkg::SKIP_W-1:0] pick_skip();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return 8'd255;
            2:       return 8'($urandom_range(0, 4));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    initial begin
        int                         n_items;
        int                         len;
        int                         kind;
        logic [31:0]                stamp;
        logic [31:0]                period;
        logic [fpsk_pkg::FPS_W-1:0] fps;

        cfg_fps      = fpsk_pkg::TARGET_FPS_RESET;
        cfg_max_skip = fpsk_pkg::MAX_SKIP_RESET;
        clear_pacing();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset defaults: on rate, zero elapsed, late with skips, wrap and backward steps.
        stamp_q = '{32'd0, 32'd40, 32'd40, 32'd130, 32'd300, 32'd400, 32'd1500,
                    32'hFFFF_FFF0, 32'h0000_0010, 32'hFFFF_FFFF, 32'h8000_0000};
        drain();

        // Pacing disabled.
        set_pacing(10'd0, fpsk_pkg::MAX_SKIP_RESET);
        stamp_q = '{32'd5, 32'd5, 32'd5, 32'd2000, 32'd7};
        drain();

        // Fastest target with no skipping allowed.
        set_pacing(10'd1000, 8'd0);
        stamp_q = '{32'd100, 32'd100, 32'd101, 32'd103, 32'd103};
        drain();

        // Slowest target with the largest skip budget.
        set_pacing(10'd1, 8'd255);
        stamp_q = '{32'd0, 32'd0, 32'd5000, 32'd6000};
        drain();

        n_items = 0;
        while (n_items < RANDOM_ITEMS) begin
            fps = pick_fps();
            set_pacing(fps, pick_skip());
            in_idle_max  = $urandom_range(0, 1) * 3;
            out_idle_max = $urandom_range(0, 1) * 3;
            len    = $urandom_range(40, 110);
            stamp  = $urandom();
            period = (fps == 0) ? 32'($urandom_range(1, 50)) : 32'(WINDOW_MS / fps);
            for (int i = 0; i < len; i++) begin
                stamp_q.push_back(stamp);
                kind = $urandom_range(0, 99);
                if (kind < 45)
                    stamp = stamp + period;
                else if (kind < 65)
                    stamp = stamp + $urandom_range(0, period);
                else if (kind < 90)
                    stamp = stamp + period + $urandom_range(0, 3 * period + 3);
                else if (kind < 95)
                    stamp = stamp;
                else
                    stamp = $urandom();
            end
            n_items += len;
            drain();
        end

        if (err_count == 0 && pace_exp_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/fpsk_pkg.sv
hdl/frame_pacer_with_skip.sv
dv/tb_frame_pacer_with_skip.sv
